// ===== rtl/core/u8u16_pkg.sv =====
// Shared types, constants and byte classification for the UTF-8 to UTF-16 decoder.
// No dependencies.
package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] HI_BASE     = 16'hD800;
    localparam logic [15:0] LO_BASE     = 16'hDC00;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_SUPP     = 21'h010000;
    localparam logic [20:0] SURR_FIRST  = 21'h00D800;
    localparam logic [20:0] SURR_END    = 21'h00E000;
    localparam logic [20:0] LEAST_2     = 21'h000080;
    localparam logic [20:0] LEAST_3     = 21'h000800;
    localparam logic [20:0] LEAST_4     = 21'h010000;
    localparam logic [7:0]  MASK_2      = 8'hE0;
    localparam logic [7:0]  MARK_2      = 8'hC0;
    localparam logic [7:0]  MASK_3      = 8'hF0;
    localparam logic [7:0]  MARK_3      = 8'hE0;
    localparam logic [7:0]  MASK_4      = 8'hF8;
    localparam logic [7:0]  MARK_4      = 8'hF0;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_head_t;

    // continuation bytes a lead asks for; zero for ASCII and invalid leads
    function automatic logic [1:0] lead_len(input logic [7:0] b);
        logic [1:0] k;
        k = 2'd0;
        if ((b & MASK_2) == MARK_2)
        begin
            k = 2'd1;
        end
        else if ((b & MASK_3) == MARK_3)
        begin
            k = 2'd2;
        end
        else if ((b & MASK_4) == MARK_4)
        begin
            k = 2'd3;
        end
        return k;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // window starting at lead is an unfinished sequence that waits for more bytes
    function automatic logic holds(input logic [7:0] lead, input logic [2:0] avail,
                                   input logic fin);
        logic [1:0] k;
        k = lead_len(lead);
        return !fin && (avail != 3'd0) && (k != 2'd0) && (avail <= {1'b0, k});
    endfunction

endpackage

// ===== rtl/core/utf8_to_utf16_decoder.sv =====
// Top level of the UTF-8 to UTF-16 decoder: input FIFO and decode engine.
// Depends on u8u16_pkg, u8u16_queue and u8u16_back.
//
// Input channel (in_valid/in_ready) takes one UTF-8 byte per item with
// string_end on the last byte of a string. Output channel (out_valid/out_ready)
// gives one UTF-16 code unit per item; run_last marks the last unit caused by
// an input byte and string_done the last unit of the string. Malformed input
// gives U+FFFD. A byte that only extends an unfinished sequence gives no unit.
// Bytes wait in a QUEUE_DEPTH entry FIFO; the engine emits one unit per cycle
// into a single output register while that register is free, and takes no new
// byte until every unit caused by the current byte has been emitted. A byte
// that completes a surrogate pair gives two units, and held bytes are decoded
// again after a malformed sequence. An accepted byte passes through the FIFO
// and then the output register before out_valid rises. While out_ready is low
// the engine stops and the FIFO fills, then in_ready drops. Reset empties the
// FIFO, drops any held partial sequence and clears out_valid.
module utf8_to_utf16_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  utf8_byte,
    input  logic        string_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        run_last,
    output logic        string_done
);

    u8u16_pkg::q_item_t in_item;
    u8u16_pkg::q_head_t head;
    logic               pop;

    assign in_item.data = utf8_byte;
    assign in_item.last = string_end;

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .pop      (pop),
        .head     (head)
    );

    u8u16_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_unit   (code_unit),
        .run_last    (run_last),
        .string_done (string_done)
    );

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_done |-> run_last)
        else $error("string_done without run_last");

    a_hi_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (code_unit[15:10] == 6'b110110) |-> !run_last)
        else $error("high surrogate closes a run");

    a_lo_follows_hi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (code_unit[15:10] == 6'b110110)
        |=> out_valid && (code_unit[15:10] == 6'b110111))
        else $error("high surrogate not followed by low surrogate");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("engine took a byte from an empty queue");

endmodule

// ===== rtl/core/u8u16_queue.sv =====
// Front end: accepts input items into a short FIFO in front of the decode engine.
// Depends on u8u16_pkg.
module u8u16_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  u8u16_pkg::q_item_t  in_item,
    input  logic                pop,
    output u8u16_pkg::q_head_t  head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8u16_pkg::q_item_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;
    logic          do_pop;

    assign in_ready   = count_reg != CW'(DEPTH);
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && head.valid;
    assign head.valid = count_reg != '0;
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/u8u16_back.sv =====
// Back end: byte window, sequence decode and one UTF-16 unit per cycle, while the
// output register is free, into the output register. Depends on u8u16_pkg.
module u8u16_back (
    input  logic               clk,
    input  logic               rst_n,
    input  u8u16_pkg::q_head_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        code_unit,
    output logic               run_last,
    output logic               string_done
);

    logic [3:0][7:0] win_reg, win_next;
    logic [2:0]      n_reg, n_next;
    logic            end_reg, end_next;
    logic            active_reg, active_next;
    logic            lo_pend_reg, lo_pend_next;
    logic [15:0]     lo_unit_reg, lo_unit_next;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     code_unit_reg, code_unit_next;
    logic            run_last_reg, run_last_next;
    logic            string_done_reg, string_done_next;

    logic [3:0][7:0] eff_win;
    logic [2:0]      eff_n;
    logic            eff_end;
    logic            go;
    logic [7:0]      lead;
    logic [1:0]      k;
    logic [2:0]      need;
    logic [20:0]     cp;
    logic [20:0]     least;
    logic [20:0]     supp;
    logic            cp_bad;
    logic [2:0]      bad_at;
    logic            emit;
    logic            pair;
    logic            hold;
    logic [15:0]     unit;
    logic [2:0]      consume;
    logic [3:0][7:0] rem_win;
    logic [2:0]      rem_n;
    logic            last;
    logic            done;

    // window as seen this cycle: a new byte is appended when no item is in progress
    always_comb
    begin
        eff_win = win_reg;
        eff_n   = n_reg;
        eff_end = end_reg;
        if (!active_reg)
        begin
            eff_win[n_reg[1:0]] = head.item.data;
            eff_n               = n_reg + 3'd1;
            eff_end             = head.item.last;
        end
    end

    assign go  = (active_reg || head.valid) && (!out_valid_reg || out_ready);
    assign pop = go && !active_reg;

    assign lead = eff_win[0];
    assign k    = u8u16_pkg::lead_len(lead);
    assign need = {1'b0, k} + 3'd1;

    always_comb
    begin
        case (k)
            2'd1:
            begin
                cp    = {10'd0, lead[4:0], eff_win[1][5:0]};
                least = u8u16_pkg::LEAST_2;
            end
            2'd2:
            begin
                cp    = {5'd0, lead[3:0], eff_win[1][5:0], eff_win[2][5:0]};
                least = u8u16_pkg::LEAST_3;
            end
            default:
            begin
                cp    = {lead[2:0], eff_win[1][5:0], eff_win[2][5:0], eff_win[3][5:0]};
                least = u8u16_pkg::LEAST_4;
            end
        endcase
    end

    assign cp_bad = (cp < least) || (cp > u8u16_pkg::CP_MAX) ||
                    ((cp >= u8u16_pkg::SURR_FIRST) && (cp < u8u16_pkg::SURR_END));
    assign supp   = cp - u8u16_pkg::CP_SUPP;

    always_comb
    begin
        if (!u8u16_pkg::is_cont(eff_win[1]))
        begin
            bad_at = 3'd1;
        end
        else if ((k >= 2'd2) && !u8u16_pkg::is_cont(eff_win[2]))
        begin
            bad_at = 3'd2;
        end
        else if ((k == 2'd3) && !u8u16_pkg::is_cont(eff_win[3]))
        begin
            bad_at = 3'd3;
        end
        else
        begin
            bad_at = 3'd0;
        end
    end

    always_comb
    begin
        emit    = 1'b0;
        pair    = 1'b0;
        hold    = 1'b0;
        unit    = u8u16_pkg::REPLACEMENT;
        consume = 3'd0;
        if (lo_pend_reg)
        begin
            emit = 1'b1;
            unit = lo_unit_reg;
        end
        else if (!lead[7])
        begin
            emit    = 1'b1;
            unit    = {8'h00, lead};
            consume = 3'd1;
        end
        else if (k == 2'd0)
        begin
            emit    = 1'b1;
            consume = 3'd1;
        end
        else if (u8u16_pkg::holds(lead, eff_n, eff_end))
        begin
            hold = 1'b1;
        end
        else if (eff_n < need)
        begin
            // string ended mid-sequence
            emit    = 1'b1;
            consume = eff_n;
        end
        else if (bad_at != 3'd0)
        begin
            emit    = 1'b1;
            consume = bad_at;
        end
        else
        begin
            emit    = 1'b1;
            consume = need;
            if (cp_bad)
            begin
                unit = u8u16_pkg::REPLACEMENT;
            end
            else if (cp < u8u16_pkg::CP_SUPP)
            begin
                unit = cp[15:0];
            end
            else
            begin
                pair = 1'b1;
                unit = u8u16_pkg::HI_BASE + 16'(supp[19:10]);
            end
        end
    end

    assign rem_win = eff_win >> {consume, 3'b000};
    assign rem_n   = eff_n - consume;
    assign last    = !pair && ((rem_n == 3'd0) || u8u16_pkg::holds(rem_win[0], rem_n, eff_end));
    assign done    = hold || (emit && last);

    always_comb
    begin
        win_next         = win_reg;
        n_next           = n_reg;
        end_next         = end_reg;
        active_next      = active_reg;
        lo_pend_next     = lo_pend_reg;
        lo_unit_next     = lo_unit_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        code_unit_next   = code_unit_reg;
        run_last_next    = run_last_reg;
        string_done_next = string_done_reg;
        if (go)
        begin
            win_next     = rem_win;
            n_next       = rem_n;
            end_next     = eff_end;
            active_next  = !done;
            lo_pend_next = pair;
            lo_unit_next = u8u16_pkg::LO_BASE + 16'(supp[9:0]);
            if (emit)
            begin
                out_valid_next   = 1'b1;
                code_unit_next   = unit;
                run_last_next    = last;
                string_done_next = last && eff_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= 3'd0;
            end_reg       <= 1'b0;
            active_reg    <= 1'b0;
            lo_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            end_reg       <= end_next;
            active_reg    <= active_next;
            lo_pend_reg   <= lo_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg         <= win_next;
        lo_unit_reg     <= lo_unit_next;
        code_unit_reg   <= code_unit_next;
        run_last_reg    <= run_last_next;
        string_done_reg <= string_done_next;
    end

    assign out_valid   = out_valid_reg;
    assign code_unit   = code_unit_reg;
    assign run_last    = run_last_reg;
    assign string_done = string_done_reg;

endmodule

// ===== tb/tb_utf8_to_utf16_decoder.sv =====
// Self-checking testbench for utf8_to_utf16_decoder: directed and random UTF-8 strings,
// with an in-bench transcoder predicting the UTF-16 units. Depends on u8u16_pkg and the RTL.
module tb_utf8_to_utf16_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        logic       drain;
    } text_byte_t;

    typedef struct {
        logic [15:0] code;
        logic        last;
        logic        done;
    } unit_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  utf8_byte = 8'h00;
    logic        string_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_done;

    text_byte_t  bytes_to_send[$];
    logic [7:0]  text[$];
    unit_t       units_due[$];
    unit_t       want;
    logic [7:0]  held_seq[4];
    int          held_len = 0;
    int          errors = 0;
    int          send_gap = 0;
    int          out_stall = 0;
    logic        calm = 1'b0;

    utf8_to_utf16_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .utf8_byte   (utf8_byte),
        .string_end  (string_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_unit   (code_unit),
        .run_last    (run_last),
        .string_done (string_done)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // expected units for one accepted byte, against the held partial sequence
    task automatic transcode_byte(input logic [7:0] b, input logic fin);
        logic [7:0]  w[5];
        logic [15:0] made[$];
        logic [7:0]  lead;
        logic [7:0]  c;
        logic [20:0] cp;
        logic [20:0] least;
        logic [20:0] v;
        logic        bad;
        int          n;
        int          pos;
        int          k;
        int          i;
        unit_t       u;
        n = 0;
        for (i = 0; i < held_len; i++)
        begin
            w[n] = held_seq[i];
            n++;
        end
        w[n] = b;
        n++;
        held_len = 0;
        pos = 0;
        while (pos < n)
        begin
            lead = w[pos];
            k = 0;
            cp = '0;
            least = '0;
            if (lead < 8'h80)
            begin
                made.insert(made.size(), {8'h00, lead});
                pos++;
                continue;
            end
            if ((lead & u8u16_pkg::MASK_2) == u8u16_pkg::MARK_2)
            begin
                k = 1;
                cp = {16'd0, lead[4:0]};
                least = u8u16_pkg::LEAST_2;
            end
            else if ((lead & u8u16_pkg::MASK_3) == u8u16_pkg::MARK_3)
            begin
                k = 2;
                cp = {17'd0, lead[3:0]};
                least = u8u16_pkg::LEAST_3;
            end
            else if ((lead & u8u16_pkg::MASK_4) == u8u16_pkg::MARK_4)
            begin
                k = 3;
                cp = {18'd0, lead[2:0]};
                least = u8u16_pkg::LEAST_4;
            end
            if (k == 0)
            begin
                made.insert(made.size(), u8u16_pkg::REPLACEMENT);
                pos++;
                continue;
            end
            if (pos + k + 1 > n)
            begin
                if (fin)
                begin
                    made.insert(made.size(), u8u16_pkg::REPLACEMENT);
                end
                else
                begin
                    for (i = pos; i < n; i++)
                    begin
                        held_seq[held_len] = w[i];
                        held_len++;
                    end
                end
                pos = n;
                continue;
            end
            bad = 1'b0;
            i = 1;
            while (i <= k && !bad)
            begin
                c = w[pos + i];
                if (c[7:6] != 2'b10)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    cp = {cp[14:0], c[5:0]};
                    i++;
                end
            end
            if (bad)
            begin
                made.insert(made.size(), u8u16_pkg::REPLACEMENT);
                pos += i;
                continue;
            end
            pos += k + 1;
            if (cp < least || cp > u8u16_pkg::CP_MAX ||
                (cp >= u8u16_pkg::SURR_FIRST && cp < u8u16_pkg::SURR_END))
            begin
                made.insert(made.size(), u8u16_pkg::REPLACEMENT);
            end
            else if (cp < u8u16_pkg::CP_SUPP)
            begin
                made.insert(made.size(), cp[15:0]);
            end
            else
            begin
                v = cp - u8u16_pkg::CP_SUPP;
                made.insert(made.size(), u8u16_pkg::HI_BASE + {6'd0, v[19:10]});
                made.insert(made.size(), u8u16_pkg::LO_BASE + {6'd0, v[9:0]});
            end
        end
        for (i = 0; i < made.size() && i < 5; i++)
        begin
            u.code = made[i];
            u.last = (i == made.size() - 1 || i == 4);
            u.done = u.last && fin;
            units_due.insert(units_due.size(), u);
        end
    endtask

    // encode cp in len bytes (overlong allowed), dropping the last cut bytes
    task automatic put_char(input logic [20:0] cp, input int len, input int cut);
        logic [7:0]  enc[4];
        logic [20:0] v;
        int          i;
        v = cp;
        for (i = len - 1; i > 0; i--)
        begin
            enc[i] = {2'b10, v[5:0]};
            v = v >> 6;
        end
        case (len)
            1: enc[0] = {1'b0, v[6:0]};
            2: enc[0] = u8u16_pkg::MARK_2 | {3'd0, v[4:0]};
            3: enc[0] = u8u16_pkg::MARK_3 | {4'd0, v[3:0]};
            default: enc[0] = u8u16_pkg::MARK_4 | {5'd0, v[2:0]};
        endcase
        for (i = 0; i < len - cut; i++)
        begin
            text.insert(text.size(), enc[i]);
        end
    endtask

    task automatic flush_string(input logic drain);
        text_byte_t t;
        int         i;
        for (i = 0; i < text.size(); i++)
        begin
            t.b = text[i];
            t.fin = (i == text.size() - 1);
            t.drain = drain && (i == 0);
            bytes_to_send.insert(bytes_to_send.size(), t);
        end
        text.delete();
    endtask

    task automatic random_string();
        int sel;
        int len;
        int nchars;
        int j;
        nchars = $urandom_range(1, 6);
        for (j = 0; j < nchars; j++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                put_char(21'($urandom_range(0, 127)), 1, 0);
            end
            else if (sel < 45)
            begin
                put_char(21'($urandom_range(21'h80, 21'h7FF)), 2, 0);
            end
            else if (sel < 58)
            begin
                put_char(21'($urandom_range(21'h800, 21'hFFFF)), 3, 0);
            end
            else if (sel < 70)
            begin
                put_char(21'($urandom_range(21'h10000, 21'h10FFFF)), 4, 0);
            end
            else if (sel < 75)
            begin
                len = $urandom_range(2, 4);
                put_char(21'($urandom_range(0, len == 2 ? 21'h7F :
                                               (len == 3 ? 21'h7FF : 21'hFFFF))),
                         len, 0);
            end
            else if (sel < 78)
            begin
                put_char(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 0);
            end
            else if (sel < 81)
            begin
                put_char(21'($urandom_range(21'hD800, 21'hDFFF)), 3, 0);
            end
            else if (sel < 88)
            begin
                len = $urandom_range(2, 4);
                put_char(21'($urandom_range(21'h80, 21'h10FFFF)), len,
                         $urandom_range(1, len - 1));
            end
            else if (sel < 93)
            begin
                text.insert(text.size(), 8'($urandom_range(8'h80, 8'hBF)));
            end
            else if (sel < 96)
            begin
                text.insert(text.size(), 8'($urandom_range(8'hF8, 8'hFF)));
            end
            else
            begin
                text.insert(text.size(), 8'($urandom_range(0, 255)));
            end
        end
        flush_string($urandom_range(0, 11) == 0);
    endtask

    initial
    begin
        text = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80};
        flush_string(1'b0);
        text = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80};
        flush_string(1'b0);
        text = '{8'hF4, 8'h90, 8'h80, 8'h80, 8'h80, 8'hFF};
        flush_string(1'b0);
        text = '{8'hF0, 8'h90, 8'hC3, 8'hA9};
        flush_string(1'b0);
        text = '{8'hE2, 8'h82};
        flush_string(1'b0);
        // the U+10FFFF string waits for the directed part to drain
        put_char(21'h10FFFF, 4, 0);
        flush_string(1'b1);
        while (bytes_to_send.size() < 340)
        begin
            random_string();
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        text_byte_t nxt;
        logic       nxt_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            calm <= bytes_to_send.size() < 60;
            if (in_valid && in_ready)
            begin
                transcode_byte(utf8_byte, string_end);
            end
            if (!in_valid || in_ready)
            begin
                nxt_valid = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (bytes_to_send.size() != 0 &&
                         !(bytes_to_send[0].drain && units_due.size() != 0))
                begin
                    nxt = bytes_to_send.pop_front();
                    nxt_valid = 1'b1;
                    utf8_byte <= nxt.b;
                    string_end <= nxt.fin;
                    if (!calm && $urandom_range(0, 5) == 0)
                    begin
                        send_gap = $urandom_range(1, 3);
                    end
                end
                in_valid <= nxt_valid;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (units_due.size() == 0)
                begin
                    $display("%0t: unexpected unit: expected none, actual %h last %b done %b",
                             $time, code_unit, run_last, string_done);
                    errors++;
                end
                else
                begin
                    want = units_due.pop_front();
                    if (code_unit !== want.code)
                    begin
                        $display("%0t: code_unit expected %h actual %h",
                                 $time, want.code, code_unit);
                        errors++;
                    end
                    if (run_last !== want.last)
                    begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.last, run_last);
                        errors++;
                    end
                    if (string_done !== want.done)
                    begin
                        $display("%0t: string_done expected %b actual %b",
                                 $time, want.done, string_done);
                        errors++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 6) == 0)
                begin
                    out_stall = $urandom_range(1, 3);
                end
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (bytes_to_send.size() != 0 || in_valid || units_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && units_due.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
